FILE: rtl/blp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_pkg
// Shared widths and helpers for the Bresenham line pixel generator.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int unsigned ColorW  = 24;
  localparam int unsigned ShaderW = 8;
  // error term carries sign plus room for twice the largest delta
  localparam int unsigned ErrExtra = 3;

  // Packed line command layout between front end and stepper:
  // x, y, rem (coord), err, inc_a, inc_b (err width), steep, step_neg,
  // color, shader.
  function automatic int unsigned cmd_bits(int unsigned coord_bits);
    cmd_bits = 3 * coord_bits + 3 * (coord_bits + ErrExtra) + 2 + ColorW + ShaderW;
  endfunction

endpackage

FILE: rtl/blp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_front
// Takes a line command, classifies it as shallow or steep and sets up the
// start point, error term, increments and pixel count for the stepper.
// ----------------------------------------------------------------------------
module blp_front #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned CMD_W      = 79
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [COORD_BITS-1:0]          start_x_i,
  input  logic [COORD_BITS-1:0]          start_y_i,
  input  logic [COORD_BITS-1:0]          end_x_i,
  input  logic [COORD_BITS-1:0]          end_y_i,
  input  logic [blp_pkg::ColorW-1:0]     line_color_i,
  input  logic [blp_pkg::ShaderW-1:0]    shader_tag_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_stall_i,
  output logic [CMD_W-1:0]               cmd_o
);
  import blp_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned E = COORD_BITS + ErrExtra;

  typedef struct packed {
    logic [C-1:0]        x;
    logic [C-1:0]        y;
    logic [C-1:0]        rem;
    logic signed [E-1:0] err;
    logic signed [E-1:0] inc_a;
    logic signed [E-1:0] inc_b;
    logic                steep;
    logic                step_neg;
    logic [ColorW-1:0]   color;
    logic [ShaderW-1:0]  shader;
  } cmd_t;

  logic signed [C:0]   dx, dy;
  logic [C-1:0]        adx, ady, major, minor;
  logic                steep, use_end;
  cmd_t                cmd_d, cmd_q;
  logic                valid_q;
  logic                load;

  always_comb begin
    dx    = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dy    = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    adx   = dx[C] ? C'(-dx) : C'(dx);
    ady   = dy[C] ? C'(-dy) : C'(dy);
    steep = ady > adx;
    major = steep ? ady : adx;
    minor = steep ? adx : ady;
    // begin at the lower end of the major axis
    use_end = steep ? dy[C] : dx[C];

    cmd_d.x        = use_end ? end_x_i : start_x_i;
    cmd_d.y        = use_end ? end_y_i : start_y_i;
    cmd_d.rem      = major;
    cmd_d.err      = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    cmd_d.inc_a    = $signed({2'b00, minor, 1'b0});
    cmd_d.inc_b    = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
    cmd_d.steep    = steep;
    cmd_d.step_neg = !((dx[C] && dy[C]) || (dx > 0 && dy > 0));
    cmd_d.color    = line_color_i;
    cmd_d.shader   = shader_tag_i;
  end

  assign in_stall_o  = valid_q && cmd_stall_i;
  assign load        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = CMD_W'(cmd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!cmd_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

FILE: rtl/blp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_queue
// Two-entry command queue between the front end and the stepper.
// ----------------------------------------------------------------------------
module blp_queue #(
  parameter int unsigned WIDTH = 79
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_stall_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_stall_i,
  output logic [WIDTH-1:0] rd_data_o
);
  import blp_pkg::*;

  localparam int unsigned Depth = 2;

  logic [WIDTH-1:0] mem_q [Depth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign wr_stall_o = count_q == 2'(Depth);
  assign rd_valid_o = count_q != 2'd0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/blp_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_stepper
// Walks one line command, one pixel per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module blp_stepper #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned CMD_W      = 79
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_stall_o,
  input  logic [CMD_W-1:0]            cmd_i,
  output logic                        pix_valid_o,
  input  logic                        pix_stall_i,
  output logic [COORD_BITS-1:0]       pixel_x_o,
  output logic [COORD_BITS-1:0]       pixel_y_o,
  output logic [blp_pkg::ColorW-1:0]  pixel_color_o,
  output logic [blp_pkg::ShaderW-1:0] pixel_shader_o,
  output logic                        last_pixel_o
);
  import blp_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned E = COORD_BITS + ErrExtra;

  typedef struct packed {
    logic [C-1:0]        x;
    logic [C-1:0]        y;
    logic [C-1:0]        rem;
    logic signed [E-1:0] err;
    logic signed [E-1:0] inc_a;
    logic signed [E-1:0] inc_b;
    logic                steep;
    logic                step_neg;
    logic [ColorW-1:0]   color;
    logic [ShaderW-1:0]  shader;
  } cmd_t;

  cmd_t         cmd_in;
  cmd_t         cur_q, cur_d;
  logic         active_q, active_d;
  logic         out_valid_q;
  logic         emit, load, hold_minor;
  logic [C-1:0] minor_step;

  assign cmd_in      = cmd_t'(cmd_i);
  assign cmd_stall_o = active_q;
  assign load        = cmd_valid_i && !active_q;
  assign emit        = active_q && (!out_valid_q || !pix_stall_i);
  assign pix_valid_o = out_valid_q;

  always_comb begin
    // shallow lines keep the minor axis on err < 0, steep ones on err <= 0
    hold_minor = cur_q.steep ? (cur_q.err[E-1] || cur_q.err == '0) : cur_q.err[E-1];
    minor_step = cur_q.step_neg ? {C{1'b1}} : C'(1);
    cur_d      = cur_q;
    active_d   = active_q;
    if (load) begin
      cur_d    = cmd_in;
      active_d = 1'b1;
    end else if (emit) begin
      if (cur_q.rem == '0) begin
        active_d = 1'b0;
      end
      cur_d.rem = cur_q.rem - C'(1);
      if (cur_q.steep) begin
        cur_d.y = cur_q.y + C'(1);
        if (!hold_minor) cur_d.x = cur_q.x + minor_step;
      end else begin
        cur_d.x = cur_q.x + C'(1);
        if (!hold_minor) cur_d.y = cur_q.y + minor_step;
      end
      cur_d.err = cur_q.err + (hold_minor ? cur_q.inc_a : cur_q.inc_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!pix_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      pixel_x_o      <= cur_q.x;
      pixel_y_o      <= cur_q.y;
      pixel_color_o  <= cur_q.color;
      pixel_shader_o <= cur_q.shader;
      last_pixel_o   <= cur_q.rem == '0;
    end
  end

endmodule

FILE: rtl/bresenham_line_pixels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_pixels
// Bresenham line rasterizer: one line command in, its pixel run out.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  endpoints, color, shader tag
//   pix      output     pix_valid_o / pix_stall_i pixel x/y, color, shader, last
//
// A line of N pixels (N = max(|dx|,|dy|) + 1, up to 2^COORD_BITS) is walked by
// the stepper: it loads the command, then emits one pixel per cycle unless the
// output stalls, set by its single error-term adder. Setup and a two-beat
// command queue run ahead, so commands are taken while a line is being walked.
// Reset clears all valid and busy flags; no payload is reset.
// A stalled pixel beat holds in the output register and freezes the stepper's pixel walk.
// ----------------------------------------------------------------------------
module bresenham_line_pixels #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [COORD_BITS-1:0]       start_x_i,
  input  logic [COORD_BITS-1:0]       start_y_i,
  input  logic [COORD_BITS-1:0]       end_x_i,
  input  logic [COORD_BITS-1:0]       end_y_i,
  input  logic [blp_pkg::ColorW-1:0]  line_color_i,
  input  logic [blp_pkg::ShaderW-1:0] shader_tag_i,
  output logic                        pix_valid_o,
  input  logic                        pix_stall_i,
  output logic [COORD_BITS-1:0]       pixel_x_o,
  output logic [COORD_BITS-1:0]       pixel_y_o,
  output logic [blp_pkg::ColorW-1:0]  pixel_color_o,
  output logic [blp_pkg::ShaderW-1:0] pixel_shader_o,
  output logic                        last_pixel_o
);
  import blp_pkg::*;

  localparam int unsigned CmdW = cmd_bits(COORD_BITS);

  logic            f_valid, f_stall;
  logic [CmdW-1:0] f_cmd;
  logic            q_valid, q_stall;
  logic [CmdW-1:0] q_cmd;

  blp_front #(
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CmdW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .line_color_i(line_color_i),
    .shader_tag_i(shader_tag_i),
    .cmd_valid_o (f_valid),
    .cmd_stall_i (f_stall),
    .cmd_o       (f_cmd)
  );

  blp_queue #(
    .WIDTH(CmdW)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_stall_o(f_stall),
    .wr_data_i (f_cmd),
    .rd_valid_o(q_valid),
    .rd_stall_i(q_stall),
    .rd_data_o (q_cmd)
  );

  blp_stepper #(
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CmdW)
  ) u_stepper (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_stall_o   (q_stall),
    .cmd_i         (q_cmd),
    .pix_valid_o   (pix_valid_o),
    .pix_stall_i   (pix_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .pixel_shader_o(pixel_shader_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

FILE: verif/pixel_run_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_run_checker
// Watches both channels of the line rasterizer. Each accepted line command is
// traced into its expected pixel run. Each accepted pixel beat is compared
// field by field with the oldest expected pixel.
// ----------------------------------------------------------------------------
module pixel_run_checker #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [COORD_BITS-1:0]       start_x_i,
  input  logic [COORD_BITS-1:0]       start_y_i,
  input  logic [COORD_BITS-1:0]       end_x_i,
  input  logic [COORD_BITS-1:0]       end_y_i,
  input  logic [blp_pkg::ColorW-1:0]  line_color_i,
  input  logic [blp_pkg::ShaderW-1:0] shader_tag_i,
  input  logic                        pix_valid_i,
  input  logic                        pix_stall_i,
  input  logic [COORD_BITS-1:0]       pixel_x_i,
  input  logic [COORD_BITS-1:0]       pixel_y_i,
  input  logic [blp_pkg::ColorW-1:0]  pixel_color_i,
  input  logic [blp_pkg::ShaderW-1:0] pixel_shader_i,
  input  logic                        last_pixel_i,
  output int                          fail_count_o,
  output int                          pixels_pending_o,
  output int                          pixels_checked_o
);
  import blp_pkg::*;

  localparam int MaxPixels = 1 << COORD_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [ColorW-1:0]     color;
    logic [ShaderW-1:0]    shader;
    logic                  last;
  } pixel_t;

  pixel_t expected_pixels[$];

  // Walk one line the Bresenham way and queue every pixel on it.
  function automatic void trace_line(input logic [COORD_BITS-1:0] xa,
                                     input logic [COORD_BITS-1:0] ya,
                                     input logic [COORD_BITS-1:0] xb,
                                     input logic [COORD_BITS-1:0] yb,
                                     input logic [ColorW-1:0]     color,
                                     input logic [ShaderW-1:0]    shader);
    int dx, dy, adx, ady, minor_step, x, y, err, len;
    bit steep;
    pixel_t px;
    dx  = int'(xb) - int'(xa);
    dy  = int'(yb) - int'(ya);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    minor_step = ((dx < 0 && dy < 0) || (dx > 0 && dy > 0)) ? 1 : -1;
    steep = (ady > adx);
    if (!steep) begin
      x   = (dx >= 0) ? int'(xa) : int'(xb);
      y   = (dx >= 0) ? int'(ya) : int'(yb);
      err = 2 * ady - adx;
      len = adx + 1;
    end else begin
      x   = (dy >= 0) ? int'(xa) : int'(xb);
      y   = (dy >= 0) ? int'(ya) : int'(yb);
      err = 2 * adx - ady;
      len = ady + 1;
    end
    if (len > MaxPixels) len = MaxPixels;
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if (!steep) begin
          x++;
          if (err < 0) begin
            err += 2 * ady;
          end else begin
            y += minor_step;
            err += 2 * (ady - adx);
          end
        end else begin
          y++;
          // steep lines take the minor step only on a strictly positive error
          if (err <= 0) begin
            err += 2 * adx;
          end else begin
            x += minor_step;
            err += 2 * (adx - ady);
          end
        end
      end
      px.x      = x[COORD_BITS-1:0];
      px.y      = y[COORD_BITS-1:0];
      px.color  = color;
      px.shader = shader;
      px.last   = (i == len - 1);
      expected_pixels.push_back(px);
    end
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      expected_pixels.delete();
      fail_count_o     = 0;
      pixels_pending_o = 0;
      pixels_checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        trace_line(start_x_i, start_y_i, end_x_i, end_y_i, line_color_i, shader_tag_i);
      end
      if (pix_valid_i && !pix_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel beat (%0d,%0d) with no pixel expected", pixel_x_i, pixel_y_i);
          fail_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.x, pixel_x_i);
          check_field("pixel_y", want.y, pixel_y_i);
          check_field("pixel_color", want.color, pixel_color_i);
          check_field("pixel_shader", want.shader, pixel_shader_i);
          check_field("last_pixel", want.last, last_pixel_i);
          pixels_checked_o++;
        end
      end
      pixels_pending_o = expected_pixels.size();
    end
  end

endmodule

FILE: verif/tb_bresenham_line_pixels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_pixels
// Drives line commands into the rasterizer: a directed set of corner lines,
// then random lines under three idle mixes, with a long output hold-off and
// drain pauses. The pixel run checker predicts and compares; this top only
// makes stimulus, runs the watchdog and reports the verdict.
// ----------------------------------------------------------------------------
module tb_bresenham_line_pixels;
  import blp_pkg::*;

  localparam int unsigned COORD_BITS = 6;
  localparam int CoordMax    = (1 << COORD_BITS) - 1;
  localparam int StallLimit  = 2000;
  localparam int LongHold    = 400;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [ColorW-1:0]     color;
    logic [ShaderW-1:0]    shader;
  } line_cmd_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [COORD_BITS-1:0] start_x_i;
  logic [COORD_BITS-1:0] start_y_i;
  logic [COORD_BITS-1:0] end_x_i;
  logic [COORD_BITS-1:0] end_y_i;
  logic [ColorW-1:0]     line_color_i;
  logic [ShaderW-1:0]    shader_tag_i;
  logic                  pix_valid_o;
  logic                  pix_stall_i;
  logic [COORD_BITS-1:0] pixel_x_o;
  logic [COORD_BITS-1:0] pixel_y_o;
  logic [ColorW-1:0]     pixel_color_o;
  logic [ShaderW-1:0]    pixel_shader_o;
  logic                  last_pixel_o;

  int fail_count;
  int pixels_pending;
  int pixels_checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase = -1;
  bit long_hold_done = 1'b0;
  int lines_sent = 0;

  bresenham_line_pixels #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .line_color_i  (line_color_i),
    .shader_tag_i  (shader_tag_i),
    .pix_valid_o   (pix_valid_o),
    .pix_stall_i   (pix_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .pixel_shader_o(pixel_shader_o),
    .last_pixel_o  (last_pixel_o)
  );

  pixel_run_checker #(
    .COORD_BITS(COORD_BITS)
  ) u_pixel_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .line_color_i    (line_color_i),
    .shader_tag_i    (shader_tag_i),
    .pix_valid_i     (pix_valid_o),
    .pix_stall_i     (pix_stall_i),
    .pixel_x_i       (pixel_x_o),
    .pixel_y_i       (pixel_y_o),
    .pixel_color_i   (pixel_color_o),
    .pixel_shader_i  (pixel_shader_o),
    .last_pixel_i    (last_pixel_o),
    .fail_count_o    (fail_count),
    .pixels_pending_o(pixels_pending),
    .pixels_checked_o(pixels_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pin_coord(input int v);
    if (v < 0) return 0;
    if (v > CoordMax) return CoordMax;
    return v;
  endfunction

  function automatic line_cmd_t random_line();
    line_cmd_t c;
    int kind, d, t;
    c.sx     = COORD_BITS'($urandom_range(CoordMax));
    c.sy     = COORD_BITS'($urandom_range(CoordMax));
    c.ex     = COORD_BITS'($urandom_range(CoordMax));
    c.ey     = COORD_BITS'($urandom_range(CoordMax));
    c.color  = ColorW'($urandom);
    c.shader = ShaderW'($urandom);
    kind = int'($urandom_range(9));
    case (kind)
      4, 5, 6: begin
        c.ex = COORD_BITS'(pin_coord(int'(c.sx) + int'($urandom_range(14)) - 7));
        c.ey = COORD_BITS'(pin_coord(int'(c.sy) + int'($urandom_range(14)) - 7));
      end
      7: begin
        if ($urandom_range(1)) c.ey = c.sy;
        else c.ex = c.sx;
      end
      8: begin
        // exact diagonal, either direction on each axis
        d    = int'($urandom_range(CoordMax));
        c.sx = COORD_BITS'($urandom_range(CoordMax - d));
        c.sy = COORD_BITS'($urandom_range(CoordMax - d));
        c.ex = COORD_BITS'(int'(c.sx) + d);
        c.ey = COORD_BITS'(int'(c.sy) + d);
        if ($urandom_range(1)) begin
          t = int'(c.sx); c.sx = c.ex; c.ex = COORD_BITS'(t);
        end
        if ($urandom_range(1)) begin
          t = int'(c.sy); c.sy = c.ey; c.ey = COORD_BITS'(t);
        end
      end
      9: begin
        c.ex = c.sx;
        c.ey = c.sy;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Offer one command and hold it until the beat is taken.
  task automatic send_line(input line_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_x_i    <= c.sx;
    start_y_i    <= c.sy;
    end_x_i      <= c.ex;
    end_y_i      <= c.ey;
    line_color_i <= c.color;
    shader_tag_i <= c.shader;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lines_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    line_cmd_t directed_set[$];
    int random_count[3];
    int directed_lines;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    start_x_i    <= '0;
    start_y_i    <= '0;
    end_x_i      <= '0;
    end_y_i      <= '0;
    line_color_i <= '0;
    shader_tag_i <= '0;
    directed_set = '{
      '{6'd5,  6'd5,  6'd5,  6'd5,  24'h000000, 8'h00},  // single point
      '{6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF, 8'hFF},  // single point at max
      '{6'd0,  6'd0,  6'd63, 6'd0,  24'hAAAAAA, 8'h55},  // full horizontal
      '{6'd63, 6'd63, 6'd0,  6'd63, 24'h555555, 8'hAA},  // horizontal, reversed
      '{6'd0,  6'd0,  6'd0,  6'd63, 24'hFFFFFF, 8'h00},  // full vertical
      '{6'd63, 6'd63, 6'd63, 6'd0,  24'h000000, 8'hFF},  // vertical, reversed
      '{6'd0,  6'd0,  6'd63, 6'd63, 24'h123456, 8'h01},  // diagonal, taken as shallow
      '{6'd0,  6'd63, 6'd63, 6'd0,  24'h654321, 8'h80},  // anti-diagonal
      '{6'd63, 6'd63, 6'd0,  6'd0,  24'hF0F0F0, 8'h0F},  // both deltas negative
      '{6'd10, 6'd20, 6'd40, 6'd30, 24'h0F0F0F, 8'hF0},  // shallow, rising
      '{6'd40, 6'd30, 6'd10, 6'd20, 24'hC3C3C3, 8'h3C},  // shallow, reversed
      '{6'd10, 6'd30, 6'd40, 6'd20, 24'h3C3C3C, 8'hC3},  // shallow, falling
      '{6'd20, 6'd10, 6'd30, 6'd40, 24'h800001, 8'h7E},  // steep, rising
      '{6'd30, 6'd40, 6'd20, 6'd10, 24'h7FFFFE, 8'h81},  // steep, reversed
      '{6'd30, 6'd10, 6'd20, 6'd40, 24'hA5A5A5, 8'h5A},  // steep, falling
      '{6'd0,  6'd0,  6'd1,  6'd0,  24'h000001, 8'h01},
      '{6'd0,  6'd0,  6'd1,  6'd1,  24'h800000, 8'h80},
      '{6'd1,  6'd0,  6'd0,  6'd1,  24'h5A5A5A, 8'hA5},
      '{6'd0,  6'd1,  6'd1,  6'd3,  24'hDEADBE, 8'hEF},
      '{6'd0,  6'd63, 6'd63, 6'd62, 24'hFEDCBA, 8'h42}   // long, one minor step
    };
    random_count   = '{40, 40, 30};
    directed_lines = directed_set.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_set[i]) send_line(directed_set[i]);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 13; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase = p;
      for (int n = 0; n < random_count[p]; n++) send_line(random_line());
      wait_drained();
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d line commands (%0d directed) and checked %0d pixels,",
             lines_sent, directed_lines, pixels_checked);
    $display("under sender- and receiver-heavy idling, free flow and a long output hold-off.");
    if (fail_count == 0 && pixels_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // pixel side: random stall, and one long hold-off once idling stops
  initial begin
    pix_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (phase == 2 && !long_hold_done) begin
        pix_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        long_hold_done = 1'b1;
        pix_stall_i <= 1'b0;
      end else begin
        pix_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog: too long without a beat on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (pix_valid_o && !pix_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles, %0d pixels still due",
             idle_cycles, pixels_pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
